/* design/lewh_pkg.sv */
// Package with the shared constants, sequencer op codes and interface structs of the line editor.
`timescale 1ns / 1ps
package lewh_pkg;

	// Sizes of the line buffer and the history. Both must be powers of two.
	localparam int LINE_MAX      = 32;
	localparam int HISTORY_DEPTH = 8;
	localparam int LW            = $clog2(LINE_MAX);
	localparam int HW            = $clog2(HISTORY_DEPTH);
	localparam int UW            = HW + 1;
	localparam int BW            = 4;
	localparam int KW            = 8;
	localparam int NUM_CFG       = 8;
	localparam int CIW           = 4;

	// Configuration register indexes.
	localparam logic [CIW-1:0] REG_BACKSPACE = 4'd0;
	localparam logic [CIW-1:0] REG_ENTER     = 4'd1;
	localparam logic [CIW-1:0] REG_LEFT      = 4'd2;
	localparam logic [CIW-1:0] REG_RIGHT     = 4'd3;
	localparam logic [CIW-1:0] REG_UP        = 4'd4;
	localparam logic [CIW-1:0] REG_DOWN      = 4'd5;
	localparam logic [CIW-1:0] REG_PRINT_LO  = 4'd6;
	localparam logic [CIW-1:0] REG_PRINT_HI  = 4'd7;

	// Datapath operations issued by the controller.
	localparam int OPW = 4;
	localparam logic [OPW-1:0] OP_NONE       = 4'd0;
	localparam logic [OPW-1:0] OP_KEY        = 4'd1;
	localparam logic [OPW-1:0] OP_EXEC       = 4'd2;
	localparam logic [OPW-1:0] OP_SHL_RD     = 4'd3;
	localparam logic [OPW-1:0] OP_SHL_WR     = 4'd4;
	localparam logic [OPW-1:0] OP_INS_RD     = 4'd5;
	localparam logic [OPW-1:0] OP_INS_WR     = 4'd6;
	localparam logic [OPW-1:0] OP_INS_PUT    = 4'd7;
	localparam logic [OPW-1:0] OP_LOAD_LEN   = 4'd8;
	localparam logic [OPW-1:0] OP_LOAD_RD    = 4'd9;
	localparam logic [OPW-1:0] OP_LOAD_WR    = 4'd10;
	localparam logic [OPW-1:0] OP_PUSH_RD    = 4'd11;
	localparam logic [OPW-1:0] OP_PUSH_WR    = 4'd12;
	localparam logic [OPW-1:0] OP_PUSH_FIN   = 4'd13;
	localparam logic [OPW-1:0] OP_ECHO_START = 4'd14;
	localparam logic [OPW-1:0] OP_ECHO_RD    = 4'd15;

	// Work that follows the decode of a key.
	localparam int KDW = 3;
	localparam logic [KDW-1:0] KIND_ECHO = 3'd0;
	localparam logic [KDW-1:0] KIND_SHL  = 3'd1;
	localparam logic [KDW-1:0] KIND_INS  = 3'd2;
	localparam logic [KDW-1:0] KIND_LOAD = 3'd3;
	localparam logic [KDW-1:0] KIND_PUSH = 3'd4;

	// Controller to datapath.
	typedef struct packed {
		logic [OPW-1:0] op;
		logic           echo_next;
		logic           echo_done;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic [KDW-1:0] kind;
		logic           lt_len;
		logic           gt_cur;
		logic           echo_last;
	} sts_t;

endpackage

/* design/lewh_ctrl.sv */
// Controller state machine that sequences key handling, copies and the echo run.
`timescale 1ns / 1ps
module lewh_ctrl import lewh_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam int SW = 4;
	localparam logic [SW-1:0] S_IDLE     = 4'd0;
	localparam logic [SW-1:0] S_EXEC     = 4'd1;
	localparam logic [SW-1:0] S_SHL_RD   = 4'd2;
	localparam logic [SW-1:0] S_SHL_WR   = 4'd3;
	localparam logic [SW-1:0] S_INS_RD   = 4'd4;
	localparam logic [SW-1:0] S_INS_WR   = 4'd5;
	localparam logic [SW-1:0] S_INS_PUT  = 4'd6;
	localparam logic [SW-1:0] S_LOAD_LEN = 4'd7;
	localparam logic [SW-1:0] S_LOAD_RD  = 4'd8;
	localparam logic [SW-1:0] S_LOAD_WR  = 4'd9;
	localparam logic [SW-1:0] S_PUSH_RD  = 4'd10;
	localparam logic [SW-1:0] S_PUSH_WR  = 4'd11;
	localparam logic [SW-1:0] S_ECHO_RD  = 4'd12;
	localparam logic [SW-1:0] S_ECHO_OUT = 4'd13;

	logic [SW-1:0] state_q;
	logic [SW-1:0] state_d;

	// Next state and the op issued in each state.
	always_comb begin
		state_d       = state_q;
		cmd.op        = OP_NONE;
		cmd.echo_next = 1'b0;
		cmd.echo_done = 1'b0;
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_KEY;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.op = OP_EXEC;
				case (sts.kind)
					KIND_SHL:  state_d = S_SHL_RD;
					KIND_INS:  state_d = S_INS_RD;
					KIND_LOAD: state_d = S_LOAD_LEN;
					KIND_PUSH: state_d = S_PUSH_RD;
					default:   state_d = S_ECHO_RD;
				endcase
			end
			S_SHL_RD: begin
				if (sts.lt_len) begin
					cmd.op  = OP_SHL_RD;
					state_d = S_SHL_WR;
				end else begin
					cmd.op  = OP_ECHO_START;
					state_d = S_ECHO_RD;
				end
			end
			S_SHL_WR: begin
				cmd.op  = OP_SHL_WR;
				state_d = S_SHL_RD;
			end
			S_INS_RD: begin
				if (sts.gt_cur) begin
					cmd.op  = OP_INS_RD;
					state_d = S_INS_WR;
				end else begin
					state_d = S_INS_PUT;
				end
			end
			S_INS_WR: begin
				cmd.op  = OP_INS_WR;
				state_d = S_INS_RD;
			end
			S_INS_PUT: begin
				cmd.op  = OP_INS_PUT;
				state_d = S_ECHO_RD;
			end
			S_LOAD_LEN: begin
				cmd.op  = OP_LOAD_LEN;
				state_d = S_LOAD_RD;
			end
			S_LOAD_RD: begin
				if (sts.lt_len) begin
					cmd.op  = OP_LOAD_RD;
					state_d = S_LOAD_WR;
				end else begin
					cmd.op  = OP_ECHO_START;
					state_d = S_ECHO_RD;
				end
			end
			S_LOAD_WR: begin
				cmd.op  = OP_LOAD_WR;
				state_d = S_LOAD_RD;
			end
			S_PUSH_RD: begin
				if (sts.lt_len) begin
					cmd.op  = OP_PUSH_RD;
					state_d = S_PUSH_WR;
				end else begin
					cmd.op  = OP_PUSH_FIN;
					state_d = S_ECHO_RD;
				end
			end
			S_PUSH_WR: begin
				cmd.op  = OP_PUSH_WR;
				state_d = S_PUSH_RD;
			end
			S_ECHO_RD: begin
				cmd.op  = OP_ECHO_RD;
				state_d = S_ECHO_OUT;
			end
			S_ECHO_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.echo_last) begin
						cmd.echo_done = 1'b1;
						state_d       = S_IDLE;
					end else begin
						cmd.echo_next = 1'b1;
						state_d       = S_ECHO_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	// A result is never offered while a new item may be taken.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && in_ready)) else $error("result offered while taking an item");
	// An accepted item always starts the decode step.
	a_key_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_EXEC)) else $error("decode skipped");
	// A run ends only with a return to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.echo_done |=> in_ready) else $error("no return to idle after echo");
`endif

endmodule

/* design/lewh_dp.sv */
// Datapath of the line editor: registers, line and history memories, key decode.
`timescale 1ns / 1ps
module lewh_dp import lewh_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CIW-1:0]        cfg_index,
	input  logic [KW-1:0]         cfg_data,
	input  logic [KW-1:0]         key_code,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output logic [KW-1:0]         char_code,
	output logic                  char_valid,
	output logic [LW-1:0]         char_pos,
	output logic [LW-1:0]         line_length,
	output logic [LW-1:0]         cursor_at,
	output logic                  committed,
	output logic signed [BW-1:0]  browse_level,
	output logic                  last
);

	logic [KW-1:0]        cfg_q [NUM_CFG];
	logic [KW-1:0]        key_q;
	logic [LW-1:0]        len_q;
	logic [LW-1:0]        cur_q;
	logic [LW-1:0]        idx_q;
	logic [UW-1:0]        used_q;
	logic [HW-1:0]        head_q;
	logic signed [BW-1:0] brw_q;
	logic                 commit_q;
	logic                 enter_q;

	logic [KW-1:0]        line_mem [LINE_MAX];
	logic [KW-1:0]        rd_q;
	logic [KW-1:0]        hist_mem [HISTORY_DEPTH*LINE_MAX];
	logic [KW-1:0]        hrd_q;
	logic [LW-1:0]        hlen_q [HISTORY_DEPTH];

	logic k_bs, k_left, k_right, k_up, k_down, k_enter, k_print;
	logic up_ok, room;
	logic [BW-1:0]  brw_inc;
	logic [HW-1:0]  slot;
	logic           lw_en;
	logic [LW-1:0]  lw_addr;
	logic [KW-1:0]  lw_data;
	logic           lr_en;
	logic [LW-1:0]  lr_addr;

	// Key decode in priority order.
	always_comb begin
		k_bs    = key_q == cfg_q[REG_BACKSPACE[2:0]];
		k_left  = !k_bs && key_q == cfg_q[REG_LEFT[2:0]];
		k_right = !k_bs && !k_left && key_q == cfg_q[REG_RIGHT[2:0]];
		k_up    = !k_bs && !k_left && !k_right && key_q == cfg_q[REG_UP[2:0]];
		k_down  = !k_bs && !k_left && !k_right && !k_up && key_q == cfg_q[REG_DOWN[2:0]];
		k_enter = !k_bs && !k_left && !k_right && !k_up && !k_down
			&& key_q == cfg_q[REG_ENTER[2:0]];
		k_print = !k_bs && !k_left && !k_right && !k_up && !k_down && !k_enter
			&& key_q >= cfg_q[REG_PRINT_LO[2:0]] && key_q <= cfg_q[REG_PRINT_HI[2:0]];
	end

	assign brw_inc = brw_q + BW'(1);
	assign up_ok   = UW'(brw_inc) < used_q;
	assign room    = len_q != LW'(LINE_MAX - 1);
	// Ring slot of the browsed entry, newest one below the head.
	assign slot    = head_q - HW'(1) - brw_q[HW-1:0];

	// Status for the controller.
	always_comb begin
		sts.kind = KIND_ECHO;
		if (k_bs && cur_q != '0) begin
			sts.kind = KIND_SHL;
		end else if ((k_up && up_ok) || (k_down && !brw_q[BW-1] && brw_q != '0)) begin
			sts.kind = KIND_LOAD;
		end else if (k_enter && len_q != '0) begin
			sts.kind = KIND_PUSH;
		end else if (k_print && room) begin
			sts.kind = KIND_INS;
		end
		sts.lt_len    = idx_q < len_q;
		sts.gt_cur    = idx_q > cur_q;
		sts.echo_last = (len_q == '0) || (idx_q == len_q - LW'(1));
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[0] <= 8'd8;
			cfg_q[1] <= 8'd10;
			cfg_q[2] <= 8'd128;
			cfg_q[3] <= 8'd129;
			cfg_q[4] <= 8'd130;
			cfg_q[5] <= 8'd131;
			cfg_q[6] <= 8'd32;
			cfg_q[7] <= 8'd126;
		end else if (cfg_valid && cfg_index < CIW'(NUM_CFG)) begin
			cfg_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	// Line memory port control.
	always_comb begin
		lw_en   = 1'b0;
		lw_addr = idx_q;
		lw_data = rd_q;
		lr_en   = 1'b0;
		lr_addr = idx_q;
		case (cmd.op)
			OP_SHL_WR: lw_en = 1'b1;
			OP_INS_WR: lw_en = 1'b1;
			OP_INS_PUT: begin
				lw_en   = 1'b1;
				lw_addr = cur_q;
				lw_data = key_q;
			end
			OP_LOAD_WR: begin
				lw_en   = 1'b1;
				lw_data = hrd_q;
			end
			OP_SHL_RD: begin
				lr_en   = 1'b1;
				lr_addr = idx_q + LW'(1);
			end
			OP_INS_RD: begin
				lr_en   = 1'b1;
				lr_addr = idx_q - LW'(1);
			end
			OP_PUSH_RD: lr_en = 1'b1;
			OP_ECHO_RD: lr_en = 1'b1;
			default: lw_en = 1'b0;
		endcase
	end

	// Line memory with a registered read.
	always_ff @(posedge clk) begin
		if (lw_en) begin
			line_mem[lw_addr] <= lw_data;
		end
		if (lr_en) begin
			rd_q <= line_mem[lr_addr];
		end
	end

	// History memory, lengths and key register.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_PUSH_WR) begin
			hist_mem[{head_q, idx_q}] <= rd_q;
		end
		if (cmd.op == OP_LOAD_RD) begin
			hrd_q <= hist_mem[{slot, idx_q}];
		end
		if (cmd.op == OP_PUSH_FIN) begin
			hlen_q[head_q] <= len_q;
		end
		if (cmd.op == OP_KEY) begin
			key_q <= key_code;
		end
	end

	// Editor state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			cur_q    <= '0;
			idx_q    <= '0;
			used_q   <= '0;
			head_q   <= '0;
			brw_q    <= '1;
			commit_q <= 1'b0;
			enter_q  <= 1'b0;
		end else begin
			case (cmd.op)
				OP_EXEC: begin
					idx_q <= '0;
					if (k_bs) begin
						if (cur_q != '0) begin
							cur_q <= cur_q - LW'(1);
							len_q <= len_q - LW'(1);
							idx_q <= cur_q - LW'(1);
						end
					end else if (k_left) begin
						if (cur_q != '0) begin
							cur_q <= cur_q - LW'(1);
						end
					end else if (k_right) begin
						if (cur_q < len_q) begin
							cur_q <= cur_q + LW'(1);
						end
					end else if (k_up) begin
						if (up_ok) begin
							brw_q <= brw_inc;
						end
					end else if (k_down) begin
						if (!brw_q[BW-1] && brw_q != '0) begin
							brw_q <= brw_q - BW'(1);
						end else if (brw_q == '0) begin
							brw_q <= '1;
							len_q <= '0;
							cur_q <= '0;
						end
					end else if (k_enter) begin
						enter_q  <= 1'b1;
						commit_q <= len_q != '0;
						cur_q    <= '0;
						brw_q    <= '1;
					end else if (k_print) begin
						if (room) begin
							idx_q <= len_q;
						end
					end
				end
				OP_SHL_WR:  idx_q <= idx_q + LW'(1);
				OP_INS_WR:  idx_q <= idx_q - LW'(1);
				OP_INS_PUT: begin
					cur_q <= cur_q + LW'(1);
					len_q <= len_q + LW'(1);
					idx_q <= '0;
				end
				OP_LOAD_LEN: begin
					len_q <= hlen_q[slot];
					cur_q <= hlen_q[slot];
					idx_q <= '0;
				end
				OP_LOAD_WR: idx_q <= idx_q + LW'(1);
				OP_PUSH_WR: idx_q <= idx_q + LW'(1);
				OP_PUSH_FIN: begin
					head_q <= head_q + HW'(1);
					if (used_q != UW'(HISTORY_DEPTH)) begin
						used_q <= used_q + UW'(1);
					end
					idx_q <= '0;
				end
				OP_ECHO_START: idx_q <= '0;
				default: begin
					if (cmd.echo_next) begin
						idx_q <= idx_q + LW'(1);
					end
					if (cmd.echo_done && enter_q) begin
						len_q    <= '0;
						commit_q <= 1'b0;
						enter_q  <= 1'b0;
					end
				end
			endcase
		end
	end

	// Result fields, all from registers.
	assign char_code    = (len_q != '0) ? rd_q : '0;
	assign char_valid   = len_q != '0;
	assign char_pos     = idx_q;
	assign line_length  = len_q;
	assign cursor_at    = cur_q;
	assign committed    = commit_q;
	assign browse_level = brw_q;
	assign last         = sts.echo_last;

`ifndef SYNTH
	// The cursor never passes the end of the line.
	a_cur_len: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= len_q) else $error("cursor beyond line end");
	// The history never counts more entries than it holds.
	a_used: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(HISTORY_DEPTH)) else $error("history overfull");
	// The browse depth stays below the number of stored lines.
	a_brw: assert property (@(posedge clk) disable iff (!arst_n)
		brw_q == '1 || (!brw_q[BW-1] && UW'(brw_q) < used_q))
		else $error("browse depth out of range");
`endif

endmodule

/* design/line_editor_with_history_unit.sv */
// Top level of the line editor with command history.
`timescale 1ns / 1ps
// One key item is taken while the block is idle; the block then edits the line and
// echoes it as a run of 1 to 31 results. An item passes an accept state and a
// decode state. It then takes a read state and a write state for each character
// moved by an insert or a backspace, copied from the history on up or down, or
// copied into the history on enter. An insert ends with a final check and the write
// of the new key, a recall starts with the length load and ends with a final check,
// and a backspace or a commit ends with a final check alone. Each echoed result
// takes a read state and then an output state, which holds until the result is
// accepted. The line memory has a registered read, so every moved or echoed
// character needs a read step and then a write or output step. No item is taken
// until the last result of the previous run has been accepted.
module line_editor_with_history_unit import lewh_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CIW-1:0]       cfg_index,
	input  logic [KW-1:0]        cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [KW-1:0]        key_code,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [KW-1:0]        char_code,
	output logic                 char_valid,
	output logic [LW-1:0]        char_pos,
	output logic [LW-1:0]        line_length,
	output logic [LW-1:0]        cursor_at,
	output logic                 committed,
	output logic signed [BW-1:0] browse_level,
	output logic                 last
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	// Sequencer.
	lewh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Storage and arithmetic.
	lewh_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.key_code     (key_code),
		.cmd          (cmd),
		.sts          (sts),
		.char_code    (char_code),
		.char_valid   (char_valid),
		.char_pos     (char_pos),
		.line_length  (line_length),
		.cursor_at    (cursor_at),
		.committed    (committed),
		.browse_level (browse_level),
		.last         (last)
	);

endmodule
